[hdl/rcppm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcppm_pkg
// Shared types and constants of the PPM frame decoder.
// ----------------------------------------------------------------------------
package rcppm_pkg;

    localparam int MAX_CHANNELS_DEF = 16;
    localparam int CH_W   = 16;   // capture and interval width
    localparam int CNT_W  = 5;    // channel count width
    localparam int IDX_W  = 4;    // channel index width
    localparam int WORD_W = 32;   // counters and time stamps

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC_MIN    = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_MIN = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_MAX = 2'd2;
    localparam logic [1:0] CFG_MIN_CHANNELS = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CH_W-1:0]  SYNC_MIN_RST     = 16'd2700;
    localparam logic [CH_W-1:0]  CHANNEL_MIN_RST  = 16'd750;
    localparam logic [CH_W-1:0]  CHANNEL_MAX_RST  = 16'd2250;
    localparam logic [CNT_W-1:0] MIN_CHANNELS_RST = 5'd4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage

[hdl/rc_ppm_frame_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_ppm_frame_decoder_core
// PPM pulse train decoder: one input item per captured edge, frames of
// channel widths out.
// ----------------------------------------------------------------------------
// Each input item yields a single status item, unless it closes a frame
// that holds enough channels. In that case the channel widths sit in a row
// of cells and shift out toward cell 0, one result item per cycle while the
// output is not stalled, and the next input item is not taken until the
// last channel of the frame has been emitted. An input item is taken
// whenever the block is not emitting a frame and the output register is
// empty or being read in the same cycle.
module rc_ppm_frame_decoder_core
    import rcppm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    // Input edges.
    input  logic         s_tvalid,
    output logic         s_tready,
    // capture_time[15:0], overcapture[16], time_now[48:17], zero pad
    input  logic [55:0]  s_tdata,
    // Results.
    output logic         m_tvalid,
    input  logic         m_tready,
    // channel_index[3:0], channel_width[19:4], channel_count[24:20],
    // frame_sequence[56:25], error_count[88:57], frame_time[120:89], zero pad
    output logic [127:0] m_tdata,
    // frame_valid[0]
    output logic         m_tuser,
    output logic         m_tlast
);

    localparam int CAP = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    // Configuration registers.
    logic [CH_W-1:0]  sync_min_reg, chan_min_reg, chan_max_reg;
    logic [CNT_W-1:0] min_chan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_min_reg <= SYNC_MIN_RST;
            chan_min_reg <= CHANNEL_MIN_RST;
            chan_max_reg <= CHANNEL_MAX_RST;
            min_chan_reg <= MIN_CHANNELS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SYNC_MIN:     sync_min_reg <= cfg_wdata;
                CFG_CHANNEL_MIN:  chan_min_reg <= cfg_wdata;
                CFG_CHANNEL_MAX:  chan_max_reg <= cfg_wdata;
                CFG_MIN_CHANNELS: min_chan_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Decoder state.
    state_t            state_reg, state_next;
    logic [CH_W-1:0]   prev_reg, prev_next;
    logic              seen_reg, seen_next;
    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [WORD_W-1:0] errors_reg, errors_next;
    logic [WORD_W-1:0] frames_reg, frames_next;
    logic [WORD_W-1:0] stamp_reg, stamp_next;
    logic [IDX_W-1:0]  emit_idx_reg, emit_idx_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic              o_fvalid_reg, o_fvalid_next;
    logic [IDX_W-1:0]  o_idx_reg, o_idx_next;
    logic [CH_W-1:0]   o_width_reg, o_width_next;
    logic [CNT_W-1:0]  o_count_reg, o_count_next;
    logic              o_last_reg, o_last_next;

    // Cell chain controls.
    logic              wr_en;
    logic [CNT_W-1:0]  wr_slot;
    logic [CH_W-1:0]   interval;
    logic              shift_en;
    logic [CH_W-1:0]   cell_q [CAP];

    logic [CH_W-1:0]   cap_time;
    logic              ovr;
    logic [WORD_W-1:0] now;
    logic              in_acc;
    logic              out_free;

    assign cap_time = s_tdata[15:0];
    assign ovr      = s_tdata[16];
    assign now      = s_tdata[48:17];
    assign interval = cap_time - prev_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    always_comb begin
        logic [WORD_W-1:0] err_t;
        logic              inf_t;
        logic [CNT_W-1:0]  fill_t;
        logic [CNT_W-1:0]  need;
        logic              pub;

        state_next    = state_reg;
        prev_next     = prev_reg;
        seen_next     = seen_reg;
        in_frame_next = in_frame_reg;
        fill_next     = fill_reg;
        errors_next   = errors_reg;
        frames_next   = frames_reg;
        stamp_next    = stamp_reg;
        emit_idx_next = emit_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_fvalid_next = o_fvalid_reg;
        o_idx_next    = o_idx_reg;
        o_width_next  = o_width_reg;
        o_count_next  = o_count_reg;
        o_last_next   = o_last_reg;
        wr_en         = 1'b0;
        wr_slot       = fill_reg;
        shift_en      = 1'b0;

        err_t  = errors_reg + {{(WORD_W-1){1'b0}}, ovr};
        inf_t  = in_frame_reg && !ovr;
        fill_t = ovr ? '0 : fill_reg;
        need   = (min_chan_reg == '0) ? CNT_W'(1) : min_chan_reg;
        pub    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    prev_next = cap_time;
                    if (!seen_reg) begin
                        seen_next = 1'b1;
                    end else if (interval >= sync_min_reg) begin
                        if (inf_t && fill_t >= need) begin
                            stamp_next  = now;
                            frames_next = frames_reg + 1'b1;
                            pub         = 1'b1;
                        end else if (inf_t && fill_t != '0) begin
                            // A short frame closed by a sync gap.
                            err_t = err_t + 1'b1;
                        end
                        if (!pub) begin
                            fill_t = '0;
                        end
                        inf_t = 1'b1;
                    end else if (inf_t && interval >= chan_min_reg &&
                                 interval <= chan_max_reg && fill_t < CAP_CNT) begin
                        wr_en   = 1'b1;
                        wr_slot = fill_t;
                        fill_t  = fill_t + 1'b1;
                    end else begin
                        err_t  = err_t + 1'b1;
                        fill_t = '0;
                        inf_t  = 1'b0;
                    end
                    errors_next   = err_t;
                    in_frame_next = inf_t;
                    fill_next     = fill_t;
                    if (pub) begin
                        state_next    = ST_EMIT;
                        emit_idx_next = '0;
                    end else begin
                        m_valid_next  = 1'b1;
                        o_fvalid_next = 1'b0;
                        o_idx_next    = '0;
                        o_width_next  = '0;
                        o_count_next  = '0;
                        o_last_next   = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    shift_en      = 1'b1;
                    m_valid_next  = 1'b1;
                    o_fvalid_next = 1'b1;
                    o_idx_next    = emit_idx_reg;
                    o_width_next  = cell_q[0];
                    o_count_next  = fill_reg;
                    o_last_next   = ({1'b0, emit_idx_reg} + 1'b1) == fill_reg;
                    emit_idx_next = emit_idx_reg + 1'b1;
                    if (o_last_next) begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev_reg     <= '0;
            seen_reg     <= 1'b0;
            in_frame_reg <= 1'b0;
            fill_reg     <= '0;
            errors_reg   <= '0;
            frames_reg   <= '0;
            stamp_reg    <= '0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prev_reg     <= prev_next;
            seen_reg     <= seen_next;
            in_frame_reg <= in_frame_next;
            fill_reg     <= fill_next;
            errors_reg   <= errors_next;
            frames_reg   <= frames_next;
            stamp_reg    <= stamp_next;
            emit_idx_reg <= emit_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_fvalid_reg <= o_fvalid_next;
        o_idx_reg    <= o_idx_next;
        o_width_reg  <= o_width_next;
        o_count_reg  <= o_count_next;
        o_last_reg   <= o_last_next;
    end

    // Channel store: cell 0 feeds the output, the others move one place
    // toward it on every emitted channel item.
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic [CH_W-1:0] nb;
        if (i == CAP - 1) begin : g_tail
            assign nb = '0;
        end else begin : g_mid
            assign nb = cell_q[i+1];
        end
        rcppm_cell u_cell (
            .aclk        (aclk),
            .wr_en       (wr_en && (wr_slot == CNT_W'(i))),
            .wr_data     (interval),
            .shift_en    (shift_en),
            .neighbor_in (nb),
            .value_out   (cell_q[i])
        );
    end

    // Counters are stable while a result waits, so they are read directly.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_fvalid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {7'd0, stamp_reg, errors_reg, frames_reg,
                       o_count_reg, o_width_reg, o_idx_reg};

endmodule

[hdl/rcppm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcppm_cell
// One channel slot of the store chain: loaded when its slot is written,
// and takes its right neighbor's value when the chain shifts out.
// ----------------------------------------------------------------------------
module rcppm_cell
    import rcppm_pkg::*;
(
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [CH_W-1:0] wr_data,
    input  logic            shift_en,
    input  logic [CH_W-1:0] neighbor_in,
    output logic [CH_W-1:0] value_out
);

    logic [CH_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            value_reg <= wr_data;
        end else if (shift_en) begin
            value_reg <= neighbor_in;
        end
    end

    assign value_out = value_reg;

endmodule
